@@ src/lpdd_pkg.sv @@
// Shared types and constants for the line-follower PID drive block.
package lpdd_pkg;

    typedef enum logic [1:0] {
        STEER_PID         = 2'd0,
        STEER_PIVOT_LEFT  = 2'd1,
        STEER_PIVOT_RIGHT = 2'd2
    } steer_mode_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P           = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D           = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEFT        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_RIGHT       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_TURN_ENABLE = 3'd7;

    localparam int SETPOINT_W = 14;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 8;

    localparam logic [SETPOINT_W-1:0] SETPOINT_RST    = 14'd5500;
    localparam logic [GAIN_W-1:0]     GAIN_P_RST      = 16'd389;
    localparam logic [GAIN_W-1:0]     GAIN_D_RST      = 16'd3277;
    localparam logic [GAIN_W-1:0]     GAIN_I_RST      = 16'd0;
    localparam logic [SPEED_W-1:0]    BASE_LEFT_RST   = 8'd160;
    localparam logic [SPEED_W-1:0]    BASE_RIGHT_RST  = 8'd160;
    localparam logic [SPEED_W-1:0]    SPEED_LIMIT_RST = 8'd250;

    localparam logic [31:0] PIVOT_LOW_LIMIT  = 32'd2000;
    localparam logic [31:0] PIVOT_HIGH_LIMIT = 32'd13000;

    localparam logic [SPEED_W-1:0] PIVOT_LEFT_RIGHT_SPEED = 8'd100;
    localparam logic [SPEED_W-1:0] PIVOT_RIGHT_LEFT_SPEED = 8'd160;

endpackage

@@ src/line_pid_differential_drive.sv @@
// Line-follower PID controller producing left/right motor duties per position sample.
//
// Usage: each item on the s_ channel is one line-position sample (s_tdata). Each
// accepted sample yields exactly one item on the m_ channel: left duty in
// m_tdata[7:0], right duty in m_tdata[15:8], steer mode in m_tuser.
// Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. Write them only while the block is idle.
//
// An accepted sample enters the input register, which feeds error, the three gain
// multiplies, sum and clamp; these land in the result register that drives m_tvalid.
// Throughput is one item per cycle while m_tready holds; the error state is updated
// as a non-pivot item leaves the input register, so samples follow without bubbles.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops once both hold an item; a waiting result holds steady.
// Reset clears both stage valids, the previous error and the integral, and
// loads the register defaults. There is no clearing pass.
module line_pid_differential_drive #(
    parameter int POSITION_BITS  = 14,
    parameter int INTEGRAL_BITS  = 24,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [POSITION_BITS-1:0] line_position, rest zero
    input  logic [((POSITION_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] left duty, [15:8] right duty
    output logic [15:0]                         m_tdata,
    // [1:0] steer_mode
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpdd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lpdd_pkg::*;

    localparam int P      = POSITION_BITS;
    localparam int IB     = INTEGRAL_BITS;
    localparam int F      = GAIN_FRAC_BITS;
    localparam int ISUM_W = ((IB > P + 1) ? IB : P + 1) + 1;
    localparam int PP_W   = GAIN_W + 1 + P + 1;
    localparam int PD_W   = GAIN_W + 1 + P + 2;
    localparam int PI_W   = GAIN_W + 1 + IB;
    localparam int PID_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 3;

    localparam logic signed [ISUM_W-1:0] IMAX = {{(ISUM_W-IB+1){1'b0}}, {(IB-1){1'b1}}};
    localparam logic signed [ISUM_W-1:0] IMIN = {{(ISUM_W-IB+1){1'b1}}, {(IB-1){1'b0}}};

    // configuration
    logic [SETPOINT_W-1:0] setpoint_reg;
    logic [GAIN_W-1:0]     gain_p_reg, gain_d_reg, gain_i_reg;
    logic [SPEED_W-1:0]    base_left_reg, base_right_reg, speed_limit_reg;
    logic                  hard_turn_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg    <= SETPOINT_RST;
            gain_p_reg      <= GAIN_P_RST;
            gain_d_reg      <= GAIN_D_RST;
            gain_i_reg      <= GAIN_I_RST;
            base_left_reg   <= BASE_LEFT_RST;
            base_right_reg  <= BASE_RIGHT_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
            hard_turn_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SETPOINT:         setpoint_reg    <= cfg_data[SETPOINT_W-1:0];
                REG_GAIN_P:           gain_p_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:           gain_d_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:           gain_i_reg      <= cfg_data[GAIN_W-1:0];
                REG_BASE_LEFT:        base_left_reg   <= cfg_data[SPEED_W-1:0];
                REG_BASE_RIGHT:       base_right_reg  <= cfg_data[SPEED_W-1:0];
                REG_SPEED_LIMIT:      speed_limit_reg <= cfg_data[SPEED_W-1:0];
                REG_HARD_TURN_ENABLE: hard_turn_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage may load when it is empty or its content moves on
    logic v1_reg, v2_reg;
    logic en1, en2;

    assign en2      = !v2_reg || m_tready;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: input register
    logic [P-1:0] pos1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            pos1_reg <= s_tdata[P-1:0];
        end
    end

    // error, derivative, saturated integral, products
    logic signed [P:0]        prev_err_reg;
    logic signed [IB-1:0]     integ_reg;
    logic [P-1:0]             sp_ext;
    logic signed [P:0]        err_c;
    logic signed [P+1:0]      diff_c;
    logic signed [ISUM_W-1:0] isum_c;
    logic signed [IB-1:0]     integ_c;
    logic                     pivot_l_c, pivot_r_c;
    logic signed [PP_W-1:0]   prod_p_c;
    logic signed [PD_W-1:0]   prod_d_c;
    logic signed [PI_W-1:0]   prod_i_c;

    always_comb begin
        for (int b = 0; b < P; b++) begin
            sp_ext[b] = (b < SETPOINT_W) ? setpoint_reg[b] : 1'b0;
        end
    end

    always_comb begin
        err_c  = $signed({1'b0, pos1_reg}) - $signed({1'b0, sp_ext});
        diff_c = $signed({err_c[P], err_c}) - $signed({prev_err_reg[P], prev_err_reg});
        isum_c = ISUM_W'(integ_reg) + ISUM_W'(err_c);
        if (isum_c > IMAX) begin
            integ_c = IMAX[IB-1:0];
        end else if (isum_c < IMIN) begin
            integ_c = IMIN[IB-1:0];
        end else begin
            integ_c = isum_c[IB-1:0];
        end
        pivot_l_c = hard_turn_reg && (32'(pos1_reg) < PIVOT_LOW_LIMIT);
        pivot_r_c = hard_turn_reg && (32'(pos1_reg) > PIVOT_HIGH_LIMIT);
        prod_p_c  = $signed({1'b0, gain_p_reg}) * err_c;
        prod_d_c  = $signed({1'b0, gain_d_reg}) * diff_c;
        prod_i_c  = $signed({1'b0, gain_i_reg}) * integ_c;
    end

    // pivot items leave the state alone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end else if (v1_reg && en2 && !pivot_l_c && !pivot_r_c) begin
            prev_err_reg <= err_c;
            integ_reg    <= integ_c;
        end
    end

    // truncate toward zero and clamp to 0..limit
    function automatic logic [SPEED_W-1:0] to_speed(input logic signed [PID_W-1:0] v,
                                                     input logic [SPEED_W-1:0] limit);
        logic [PID_W-F-1:0] whole;
        whole = v[PID_W-1:F];
        if (v <= 0) begin
            return '0;
        end else if (whole > (PID_W-F)'(limit)) begin
            return limit;
        end else begin
            return whole[SPEED_W-1:0];
        end
    endfunction

    logic signed [PID_W-1:0] pid_c, lsum_c, rsum_c;
    logic [SPEED_W-1:0]      left_c, right_c;
    steer_mode_t             mode_c;

    always_comb begin
        pid_c  = PID_W'(prod_p_c) + PID_W'(prod_d_c) + PID_W'(prod_i_c);
        rsum_c = $signed({{(PID_W-SPEED_W-F){1'b0}}, base_right_reg, {F{1'b0}}}) + pid_c;
        lsum_c = $signed({{(PID_W-SPEED_W-F){1'b0}}, base_left_reg, {F{1'b0}}}) - pid_c;
        if (pivot_l_c) begin
            left_c  = '0;
            right_c = PIVOT_LEFT_RIGHT_SPEED;
            mode_c  = STEER_PIVOT_LEFT;
        end else if (pivot_r_c) begin
            left_c  = PIVOT_RIGHT_LEFT_SPEED;
            right_c = '0;
            mode_c  = STEER_PIVOT_RIGHT;
        end else begin
            left_c  = to_speed(lsum_c, speed_limit_reg);
            right_c = to_speed(rsum_c, speed_limit_reg);
            mode_c  = STEER_PID;
        end
    end

    // stage 2: result register
    logic [SPEED_W-1:0] left_reg, right_reg;
    steer_mode_t        mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            left_reg  <= left_c;
            right_reg <= right_c;
            mode_reg  <= mode_c;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = {right_reg, left_reg};
    assign m_tuser  = mode_reg;

endmodule

@@ src/lpdd_checker.sv @@
// Port-level checker for the line-follower PID drive block, with its bind.
module lpdd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import lpdd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pivot_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STEER_PIVOT_LEFT) |->
            (m_tdata == {PIVOT_LEFT_RIGHT_SPEED, 8'd0}))
        else $error("pivot left speeds wrong");

    a_pivot_right: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STEER_PIVOT_RIGHT) |->
            (m_tdata == {8'd0, PIVOT_RIGHT_LEFT_SPEED}))
        else $error("pivot right speeds wrong");

endmodule

bind line_pid_differential_drive lpdd_checker u_lpdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
